// File: rtl/lpcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants for the length-prefixed chunk deframer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  // Byte codes of the framing syntax
  localparam logic [7:0] SYM_DELIM  = 8'h3A;
  localparam logic [7:0] SYM_ESCAPE = 8'h5C;
  localparam logic [7:0] SYM_ZERO   = 8'h30;
  localparam logic [7:0] RADIX      = 8'd10;

  // Result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CONTROL = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       chunk_end;
    logic       run_last;
    logic       length_overflow;
  } result_t;

  // Up to two results produced by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_out_t;

endpackage
`default_nettype wire

// File: rtl/lpcd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcd_parser
// Parse state and combinational byte decode; yields up to two results per byte.
// ----------------------------------------------------------------------------
module lpcd_parser
  import lpcd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] byte_q,
  output parse_out_t      po
);

  localparam int WIDE_BITS = LENGTH_BITS + 4;

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_ESCAPED = 2'd1,
    MODE_LENGTH  = 2'd2,
    MODE_CHUNK   = 2'd3
  } mode_t;

  mode_t                  mode, mode_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic                   overflow_seen, overflow_seen_next;

  logic [7:0]             diff;
  logic [3:0]             digit;
  logic                   is_digit;
  logic                   is_escape;
  logic                   is_delim;
  logic [LENGTH_BITS-1:0] dec;
  logic                   data_end;
  logic [WIDE_BITS-1:0]   wide;
  logic                   rem_zero;

  assign diff      = byte_q - SYM_ZERO;
  assign digit     = diff[3:0];
  assign is_digit  = diff < RADIX;
  assign is_escape = byte_q == SYM_ESCAPE;
  assign is_delim  = byte_q == SYM_DELIM;
  assign rem_zero  = remaining == '0;
  assign dec       = rem_zero ? remaining : remaining - LENGTH_BITS'(1);
  assign data_end  = dec == '0;

  // remaining * 10 + digit, four spare bits catch saturation
  assign wide = ({4'b0, remaining} << 3) + ({4'b0, remaining} << 1)
              + WIDE_BITS'(digit);

  always_comb begin
    mode_next          = mode;
    remaining_next     = remaining;
    overflow_seen_next = overflow_seen;
    po                 = '0;
    po.first.length_overflow  = overflow_seen;
    po.second.length_overflow = overflow_seen;

    case (mode)
      MODE_CONTROL: begin
        if (is_digit) begin
          mode_next      = MODE_LENGTH;
          remaining_next = LENGTH_BITS'(digit);
        end else if (is_escape) begin
          mode_next = MODE_ESCAPED;
        end else begin
          po.first.kind  = KIND_CONTROL;
          po.first.value = byte_q;
          po.count       = 2'd1;
        end
      end
      MODE_ESCAPED: begin
        mode_next      = MODE_CONTROL;
        po.first.kind  = KIND_CONTROL;
        po.first.value = byte_q;
        po.count       = 2'd1;
      end
      MODE_LENGTH: begin
        if (is_digit) begin
          if (wide[WIDE_BITS-1:LENGTH_BITS] != 4'b0) begin
            remaining_next     = '1;
            overflow_seen_next = 1'b1;
          end else begin
            remaining_next = wide[LENGTH_BITS-1:0];
          end
        end else if (is_delim) begin
          if (rem_zero) begin
            mode_next          = MODE_CONTROL;
            po.first.kind      = KIND_EMPTY;
            po.first.chunk_end = 1'b1;
            po.count           = 2'd1;
          end else begin
            mode_next = MODE_CHUNK;
          end
        end else if (rem_zero) begin
          // Empty chunk, then parse the terminating byte as a control byte
          po.first.kind      = KIND_EMPTY;
          po.first.chunk_end = 1'b1;
          if (is_escape) begin
            mode_next = MODE_ESCAPED;
            po.count  = 2'd1;
          end else begin
            mode_next       = MODE_CONTROL;
            po.second.kind  = KIND_CONTROL;
            po.second.value = byte_q;
            po.count        = 2'd2;
          end
        end else begin
          // Terminating byte is the first data byte
          remaining_next     = dec;
          mode_next          = data_end ? MODE_CONTROL : MODE_CHUNK;
          po.first.kind      = KIND_DATA;
          po.first.value     = byte_q;
          po.first.chunk_end = data_end;
          po.count           = 2'd1;
        end
      end
      default: begin
        remaining_next     = dec;
        if (data_end) begin
          mode_next = MODE_CONTROL;
        end
        po.first.kind      = KIND_DATA;
        po.first.value     = byte_q;
        po.first.chunk_end = data_end;
        po.count           = 2'd1;
      end
    endcase

    po.first.run_last  = po.count == 2'd1;
    po.second.run_last = po.count == 2'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_CONTROL;
      remaining     <= '0;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      mode          <= mode_next;
      remaining     <= remaining_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lpcd_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcd_result_fifo
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module lpcd_result_fifo
  import lpcd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire parse_out_t                po,
  input  wire logic                      pop,
  output result_t                        head,
  output logic                           head_valid,
  output logic                           room2,
  output logic [QUEUE_CNT_BITS-1:0]      count
);

  result_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] push_n;
  logic                      pop_go;

  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign room2      = count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
  assign pop_go     = pop && head_valid;
  assign push_n     = push ? QUEUE_CNT_BITS'(po.count) : '0;

  always_ff @(posedge clk) begin
    if (push && po.count != 2'd0) begin
      mem[wr_ptr] <= po.first;
    end
    if (push && po.count == 2'd2) begin
      mem[wr_ptr + QUEUE_PTR_BITS'(1)] <= po.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(push_n);
      if (pop_go) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      count <= count + push_n - QUEUE_CNT_BITS'(pop_go);
    end
  end

endmodule
`default_nettype wire

// File: rtl/length_prefixed_chunk_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_chunk_deframer_unit
// Byte-wise deframer of a length-prefixed chunk stream.
// An accepted byte is registered, then decoded and written to the result queue.
// Throughput: 1 byte per cycle while the queue has room; one result leaves per
//   cycle, so a byte that yields an empty marker plus a control symbol gives the output two results.
// The 4-entry result queue absorbs stalls; input stalls when it has < 2 free.
// Reset (rst, synchronous): control symbol mode, zero length, flag cleared.
// ----------------------------------------------------------------------------
module length_prefixed_chunk_deframer_unit
  import lpcd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      value,
  output logic            chunk_end,
  output logic            run_last,
  output logic            length_overflow
);

  logic                      in_q_valid;
  logic [7:0]                byte_q;
  logic                      proc_go;
  logic                      room2;
  logic [QUEUE_CNT_BITS-1:0] q_count;
  parse_out_t                po;
  result_t                   head;

  assign proc_go  = in_q_valid && room2;
  assign in_ready = !in_q_valid || proc_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= byte_in;
    end
  end

  lpcd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (proc_go),
    .byte_q (byte_q),
    .po     (po)
  );

  lpcd_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (proc_go),
    .po         (po),
    .pop        (out_ready),
    .head       (head),
    .head_valid (out_valid),
    .room2      (room2),
    .count      (q_count)
  );

  assign kind            = head.kind;
  assign value           = head.value;
  assign chunk_end       = head.chunk_end;
  assign run_last        = head.run_last;
  assign length_overflow = head.length_overflow;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("result queue over capacity");

  a_control_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CONTROL |-> !chunk_end)
    else $error("control symbol marked as chunk end");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> value == 8'd0 && chunk_end)
    else $error("malformed empty chunk marker");

  a_two_results_order: assert property (@(posedge clk) disable iff (rst)
    proc_go && po.count == 2'd2 |-> po.first.kind == KIND_EMPTY
      && !po.first.run_last && po.second.run_last)
    else $error("two-result byte out of order");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind != 2'd3)
    else $error("undefined result kind");

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds framed byte streams into the chunk deframer: escapes, length prefixes
// with and without the colon, empty chunks and a saturating length. Every
// request that is taken is decoded in the bench, and each result that leaves
// the block is checked against the oldest decoded result.
// ----------------------------------------------------------------------------
module testbench
  import lpcd_pkg::*;
();

  localparam int LENGTH_BITS = LENGTH_BITS_DEF;
  localparam longint unsigned LENGTH_MAX = (64'd1 << LENGTH_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_TARGET = 450;

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_ESCAPED = 2'd1,
    MODE_LENGTH  = 2'd2,
    MODE_CHUNK   = 2'd3
  } parse_mode_t;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } framed_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] value;
  logic       chunk_end;
  logic       run_last;
  logic       length_overflow;

  framed_byte_t framed_bytes[$];
  result_t      awaited_results[$];
  int           failures = 0;
  int           results_seen = 0;
  int           cycle_count = 0;

  // Decoder state of the bench
  parse_mode_t     mode = MODE_CONTROL;
  longint unsigned remaining = 0;
  logic            overflow_seen = 1'b0;
  result_t         step_results[2];
  int              step_count;

  length_prefixed_chunk_deframer_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_in(byte_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .value(value),
    .chunk_end(chunk_end),
    .run_last(run_last),
    .length_overflow(length_overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] b);
    return b >= SYM_ZERO && b <= SYM_ZERO + 8'd9;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] v, input logic e);
    step_results[step_count] = '{kind: k, value: v, chunk_end: e, run_last: 1'b0,
                                 length_overflow: overflow_seen};
    step_count++;
  endtask

  task automatic control_step(input logic [7:0] b);
    if (is_digit(b)) begin
      mode = MODE_LENGTH;
      remaining = b - SYM_ZERO;
    end else if (b == SYM_ESCAPE) begin
      mode = MODE_ESCAPED;
    end else begin
      emit(KIND_CONTROL, b, 1'b0);
    end
  endtask

  task automatic data_step(input logic [7:0] b);
    logic last_byte;
    if (remaining > 0) remaining--;
    last_byte = (remaining == 0);
    if (last_byte) mode = MODE_CONTROL;
    emit(KIND_DATA, b, last_byte);
  endtask

  // Decode one byte and queue the results it gives, in order.
  task automatic deframe_byte(input logic [7:0] b);
    longint unsigned d;
    step_count = 0;
    case (mode)
      MODE_CONTROL: control_step(b);
      MODE_ESCAPED: begin
        mode = MODE_CONTROL;
        emit(KIND_CONTROL, b, 1'b0);
      end
      MODE_LENGTH: begin
        if (is_digit(b)) begin
          d = b - SYM_ZERO;
          if (remaining > (LENGTH_MAX - d) / RADIX) begin
            remaining = LENGTH_MAX;
            overflow_seen = 1'b1;
          end else begin
            remaining = remaining * RADIX + d;
          end
        end else if (b == SYM_DELIM) begin
          if (remaining == 0) begin
            mode = MODE_CONTROL;
            emit(KIND_EMPTY, 8'd0, 1'b1);
          end else begin
            mode = MODE_CHUNK;
          end
        end else if (remaining == 0) begin
          // empty chunk, then parse the terminating byte as control
          mode = MODE_CONTROL;
          emit(KIND_EMPTY, 8'd0, 1'b1);
          control_step(b);
        end else begin
          mode = MODE_CHUNK;
          data_step(b);
        end
      end
      default: data_step(b);
    endcase
    for (int i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_results[i].run_last = 1'b1;
      awaited_results.push_back(step_results[i]);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Sender
  always @(posedge clk) begin
    framed_byte_t item;
    int unsigned send_gap;
    int unsigned send_steady;
    if (rst) begin
      in_valid <= 1'b0;
      byte_in <= 8'd0;
      send_gap = 0;
      send_steady = 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(byte_in);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (framed_bytes.size() > 0 &&
                     (!framed_bytes[0].drain_first || awaited_results.size() == 0)) begin
          item = framed_bytes.pop_front();
          in_valid <= 1'b1;
          byte_in <= item.data;
          if (send_steady > 0) send_steady--;
          else if ($urandom_range(0, 99) < 3) send_steady = $urandom_range(20, 60);
          send_gap = (send_steady > 0) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  always @(posedge clk) begin
    result_t want;
    int unsigned recv_hold;
    int unsigned recv_steady;
    bit long_hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold = 0;
      recv_steady = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: kind %0d value %0d", kind, value);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("value", want.value, value);
          check_field("chunk_end", want.chunk_end, chunk_end);
          check_field("run_last", want.run_last, run_last);
          check_field("length_overflow", want.length_overflow, length_overflow);
        end
      end
      // hold off once long enough to back up the input
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        recv_hold = 250;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        if (recv_steady > 0) recv_steady--;
        else if ($urandom_range(0, 99) < 3) recv_steady = $urandom_range(20, 60);
        recv_hold = (recv_steady > 0) ? 0 : pick_gap();
        out_ready <= (recv_hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input bit drain_first = 1'b0);
    framed_bytes.push_back('{data: b, drain_first: drain_first});
  endtask

  task automatic add_digits(input string digits);
    for (int i = 0; i < digits.len(); i++) add_byte(digits[i]);
  endtask

  function automatic logic [7:0] pick_terminator();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (is_digit(b) || b == SYM_DELIM);
    return b;
  endfunction

  initial begin
    int unsigned len;
    int unsigned pick;
    logic [7:0] b;
    string digits;
    bit drain_now;

    // Directed: control symbols at the byte extremes, escapes, both length forms
    add_byte(8'h41);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(SYM_DELIM);
    add_byte(SYM_ESCAPE); add_byte("5");
    add_byte(SYM_ESCAPE); add_byte(SYM_ESCAPE);
    add_digits("3"); add_byte(SYM_DELIM); add_byte(8'hFF); add_byte(8'h00); add_byte("7");
    add_digits("2"); add_byte("x"); add_byte("y");
    add_digits("0"); add_byte(SYM_DELIM);
    add_digits("0"); add_byte("Q");
    add_digits("0"); add_byte(SYM_ESCAPE); add_byte("7");

    // Random frames; the first one waits for the block to drain
    drain_now = 1'b1;
    while (framed_bytes.size() < RANDOM_TARGET - 35) begin
      if ($urandom_range(0, 99) < 2) drain_now = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        digits = $sformatf("%0d", len);
        if ($urandom_range(0, 3) == 0) digits = {"0", digits};
        add_byte(digits[0], drain_now);
        add_digits(digits.substr(1, digits.len() - 1));
        if ($urandom_range(0, 1)) begin
          add_byte(SYM_DELIM);
          for (int i = 0; i < len; i++) add_byte($urandom_range(0, 255));
        end else begin
          add_byte(pick_terminator());
          for (int i = 1; i < len; i++) add_byte($urandom_range(0, 255));
        end
      end else if (pick < 60) begin
        do b = $urandom_range(0, 255); while (is_digit(b) || b == SYM_ESCAPE);
        add_byte(b, drain_now);
      end else if (pick < 70) begin
        add_byte(SYM_ESCAPE, drain_now);
        add_byte($urandom_range(0, 255));
      end else if (pick < 85) begin
        add_byte("0", drain_now);
        add_byte($urandom_range(0, 1) ? SYM_DELIM : pick_terminator());
      end else begin
        add_byte($urandom_range(0, 255), drain_now);
      end
      drain_now = 1'b0;
    end

    // Largest length that fits, then one more digit saturates it; the chunk never ends
    add_byte(";", 1'b1);
    add_digits($sformatf("%0d", LENGTH_MAX));
    add_byte("1");
    add_byte(SYM_DELIM);
    for (int i = 0; i < 16; i++) add_byte($urandom_range(0, 255));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (framed_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lpcd_pkg.sv
rtl/lpcd_parser.sv
rtl/lpcd_result_fifo.sv
rtl/length_prefixed_chunk_deframer_unit.sv
test/testbench.sv
